>>> src/pncs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pncs_pkg
// Shared types and constants of the phase-noise cosine source.
// ----------------------------------------------------------------------------
package pncs_pkg;

    localparam int CORDIC_W = 34;
    localparam int SCALE_W  = 58;
    localparam int MOD_STEPS = 33;
    localparam int ATAN_DEPTH = 32;

    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 34'sh0_8000_0000;

    localparam logic [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    localparam logic [7:0] REG_MODULUS         = 8'd0;
    localparam logic [7:0] REG_INDEX_STEP      = 8'd1;
    localparam logic [7:0] REG_TURNS_PER_COUNT = 8'd2;
    localparam logic [7:0] REG_AMPLITUDE       = 8'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ROT,
        S_SCALE,
        S_EMIT
    } t_state;

endpackage

>>> src/pncs_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pncs_mod
// Bit-serial remainder of a 33-bit sum by a 32-bit modulus, one bit a cycle.
// ----------------------------------------------------------------------------
module pncs_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [31:0] i_modulus,
    output logic        o_busy,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [32:0] r_dvd;
    logic [31:0] r_rem;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {r_rem, r_dvd[32]};
    assign diff  = trial - {1'b0, i_modulus};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
            r_dvd <= i_dividend;
            if (i_modulus == 32'd0) begin
                r_busy <= 1'b0;
                r_rem  <= i_dividend[31:0];
            end else begin
                r_busy <= 1'b1;
                r_rem  <= '0;
            end
        end else if (r_busy) begin
            r_dvd <= {r_dvd[31:0], 1'b0};
            if (trial >= {1'b0, i_modulus}) begin
                r_rem <= diff[31:0];
            end else begin
                r_rem <= trial[31:0];
            end
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(pncs_pkg::MOD_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

>>> src/pncs_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pncs_cordic
// Rotation-mode CORDIC cosine, one shared shift-add step per cycle.
// ----------------------------------------------------------------------------
module pncs_cordic #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [31:0]                          i_turn,
    output logic                                 o_done,
    output logic signed [pncs_pkg::CORDIC_W-1:0] o_cos
);

    localparam int W  = pncs_pkg::CORDIC_W;
    localparam int CW = $clog2(CORDIC_ITERATIONS + 1);

    logic                r_busy;
    logic [CW-1:0]       r_cnt;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic                r_neg;

    logic signed [W-1:0] z_in;
    logic signed [W-1:0] z_fold;
    logic                fold;
    logic [4:0]          step;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] angle;

    always_comb begin
        z_in = W'($signed(i_turn));
        fold = (z_in > pncs_pkg::QUARTER_TURN) || (z_in < -pncs_pkg::QUARTER_TURN);
        if (!fold) begin
            z_fold = z_in;
        end else if (z_in > 0) begin
            z_fold = z_in - pncs_pkg::HALF_TURN;
        end else begin
            z_fold = z_in + pncs_pkg::HALF_TURN;
        end
        step  = 5'(r_cnt);
        dx    = r_y >>> step;
        dy    = r_x >>> step;
        angle = $signed({2'b00, pncs_pkg::ATAN_TURNS[step]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_x    <= pncs_pkg::GAIN_Q30;
            r_y    <= '0;
            r_z    <= z_fold;
            r_neg  <= fold;
        end else if (r_busy) begin
            if (!r_z[W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - angle;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + angle;
            end
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(CORDIC_ITERATIONS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(CORDIC_ITERATIONS - 1));
    assign o_cos  = r_neg ? -r_x : r_x;

endmodule

>>> src/phase_noise_cosine_source_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_noise_cosine_source_core
// Cosine oscillator with per-word phase-noise injection.
// ----------------------------------------------------------------------------
// Each input word carries one phase-noise value and yields one output word,
// amplitude * cos(phase index * turns_per_count + noise), rounded and
// saturated. At the default settings the 33-step bit-serial remainder that
// advances the phase index, rather than the CORDIC that runs
// CORDIC_ITERATIONS steps alongside it, sets how long a word takes from
// acceptance to result, and a new word is accepted only after the result
// is emitted. A zero modulus skips the remainder, so the CORDIC sets the pace.
// A waiting result sits in the output register while the next word is
// accepted. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module phase_noise_cosine_source_core #(
    parameter int PHASE_BITS        = 32,
    parameter int SAMPLE_BITS       = 24,
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_phase_noise,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int W  = pncs_pkg::CORDIC_W;
    localparam int SW = pncs_pkg::SCALE_W;
    localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
    localparam logic signed [SW-1:0] HALF_LSB = SW'(64'sd1 <<< 29);

    pncs_pkg::t_state r_state, n_state;

    logic [31:0] r_modulus;
    logic [31:0] r_index_step;
    logic [31:0] r_turns_per_count;
    logic [22:0] r_amplitude;
    logic [31:0] r_phase_index;
    logic [31:0] r_noise;
    logic [63:0] r_prod;
    logic signed [SW-1:0] r_scaled;
    logic                 r_out_valid;
    logic [SAMPLE_BITS-1:0] r_sample;

    logic [PHASE_BITS+31:0] noise_w;
    logic [PHASE_BITS-1:0]  acc;
    logic [PHASE_BITS+31:0] acc_w;
    logic [31:0]            turn;
    logic                   cordic_start;
    logic                   cordic_done;
    logic signed [W-1:0]    cos_val;
    logic                   mod_start;
    logic                   mod_busy;
    logic [31:0]            mod_rem;
    logic signed [SW-1:0]   rounded;
    logic signed [SW-1:0]   clamped;
    logic                   out_free;
    logic                   emit;

    assign noise_w = {r_noise, {PHASE_BITS{1'b0}}};
    assign acc     = r_prod[PHASE_BITS-1:0] + noise_w[PHASE_BITS+31:32];
    assign acc_w   = {acc, 32'h0};
    assign turn    = acc_w[PHASE_BITS+31:PHASE_BITS];

    assign rounded = (r_scaled + HALF_LSB) >>> 30;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        if (rounded > SMAX) begin
            clamped = SMAX;
        end else if (rounded < SMIN) begin
            clamped = SMIN;
        end else begin
            clamped = rounded;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        cordic_start = 1'b0;
        mod_start    = 1'b0;
        emit         = 1'b0;
        case (r_state)
            pncs_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = pncs_pkg::S_MUL;
                end
            end
            pncs_pkg::S_MUL: begin
                cordic_start = 1'b1;
                mod_start    = 1'b1;
                n_state      = pncs_pkg::S_ROT;
            end
            pncs_pkg::S_ROT: begin
                if (cordic_done) begin
                    n_state = pncs_pkg::S_SCALE;
                end
            end
            pncs_pkg::S_SCALE: begin
                n_state = pncs_pkg::S_EMIT;
            end
            pncs_pkg::S_EMIT: begin
                if (!mod_busy && out_free) begin
                    emit    = 1'b1;
                    n_state = pncs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pncs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pncs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus         <= 32'd1;
            r_index_step      <= 32'd1;
            r_turns_per_count <= 32'd0;
            r_amplitude       <= 23'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pncs_pkg::REG_MODULUS:         r_modulus         <= i_cfg_data;
                pncs_pkg::REG_INDEX_STEP:      r_index_step      <= i_cfg_data;
                pncs_pkg::REG_TURNS_PER_COUNT: r_turns_per_count <= i_cfg_data;
                pncs_pkg::REG_AMPLITUDE:       r_amplitude       <= i_cfg_data[22:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pncs_pkg::S_IDLE && i_valid) begin
            r_noise <= i_phase_noise;
            r_prod  <= 64'(r_phase_index) * 64'(r_turns_per_count);
        end
        if (r_state == pncs_pkg::S_SCALE) begin
            r_scaled <= SW'($signed({1'b0, r_amplitude})) * SW'(cos_val);
        end
        if (emit) begin
            r_sample <= clamped[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_index <= 32'd1;
            r_out_valid   <= 1'b0;
        end else begin
            if (emit) begin
                r_phase_index <= mod_rem;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    pncs_cordic #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_turn  (turn),
        .o_done  (cordic_done),
        .o_cos   (cos_val)
    );

    pncs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend ({1'b0, r_phase_index} + {1'b0, r_index_step}),
        .i_modulus  (r_modulus),
        .o_busy     (mod_busy),
        .o_rem      (mod_rem)
    );

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_sample    = r_sample;

endmodule
